FILE: design/debris_flow_outflow_minimization_macros.svh
// ----------------------------------------------------------------------------
// Debris outflow macros
// Assertion shorthands shared by the outflow block.
// ----------------------------------------------------------------------------
`ifndef DEBRIS_FLOW_OUTFLOW_MINIMIZATION_MACROS_SVH
`define DEBRIS_FLOW_OUTFLOW_MINIMIZATION_MACROS_SVH

// check an implication on every edge outside reset
`define DFOM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check a next-cycle consequence, reset included
`define DFOM_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/dfom_pkg.sv
// ----------------------------------------------------------------------------
// Debris outflow package
// Widths, register codes, cell word type and level sum helpers.
// ----------------------------------------------------------------------------
package dfom_pkg;

   localparam int NB          = 5;   // center level plus four neighbors
   localparam int LW          = 33;  // level width, signed
   localparam int SW          = 36;  // sum and average width, signed
   localparam int DW          = 35;  // dividend magnitude width
   localparam int MW          = 31;  // mobile mass width
   localparam int FW          = 31;  // flow width
   localparam int CW          = 3;   // level count width
   localparam int EPS_W       = 16;
   localparam int RELAX_W     = 17;
   localparam int RELAX_FRAC  = 16;
   localparam int PROD_W      = DW + RELAX_W;
   localparam int DIV_STEPS   = 7;
   localparam int DIV_STAGES  = DW / DIV_STEPS;
   localparam int PASSES      = NB;

   localparam logic [EPS_W-1:0]   EPS_RESET   = 16'd66;
   localparam logic [RELAX_W-1:0] RELAX_RESET = 17'd32768;
   localparam logic [FW-1:0]      FLOW_MAX    = {FW{1'b1}};

   localparam logic CFG_EPSILON    = 1'b0;
   localparam logic CFG_RELAXATION = 1'b1;

   typedef struct packed {
      logic                     active;
      logic [NB-1:0]            gone;
      logic [MW-1:0]            mass;
      logic [NB-1:0][LW-1:0]    lvl;
   } cell_type;

   function automatic logic signed [SW-1:0] cell_sum(cell_type c);
      logic signed [SW-1:0] s;
      s = SW'(c.mass);
      for (int n = 0; n < NB; n++) begin
         if (!c.gone[n]) s = s + SW'($signed(c.lvl[n]));
      end
      return s;
   endfunction

   function automatic logic [CW-1:0] cell_cnt(cell_type c);
      logic [CW-1:0] k;
      k = '0;
      for (int n = 0; n < NB; n++) begin
         if (!c.gone[n]) k = k + CW'(1);
      end
      return k;
   endfunction

endpackage

FILE: design/dfom_pass.sv
// ----------------------------------------------------------------------------
// Elimination pass
// Sums the mass and the remaining levels, then drops every level at or above
// the floor average. Two register stages.
// ----------------------------------------------------------------------------
module dfom_pass import dfom_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  cell_type in_cell,
   output logic     out_valid,
   output cell_type out_cell
);

   logic                 a_valid_ff;
   cell_type             a_cell_ff;
   logic signed [SW-1:0] a_sum_ff;
   logic [CW-1:0]        a_cnt_ff;
   logic                 b_valid_ff;
   cell_type             b_cell_ff;
   cell_type             b_cell_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_cell_ff <= in_cell;
         a_sum_ff  <= cell_sum(in_cell);
         a_cnt_ff  <= cell_cnt(in_cell);
         b_cell_ff <= b_cell_in;
      end
   end

   // floor(sum/cnt) <= lvl  is  sum <= lvl*cnt + cnt - 1
   always_comb begin
      logic signed [SW-1:0] lv;
      logic signed [SW-1:0] cv;
      logic signed [SW-1:0] bound;
      b_cell_in = a_cell_ff;
      cv = SW'(a_cnt_ff);
      for (int n = 0; n < NB; n++) begin
         lv    = SW'($signed(a_cell_ff.lvl[n]));
         bound = lv * cv + cv - SW'(1);
         if (a_cnt_ff != '0 && a_sum_ff <= bound) b_cell_in.gone[n] = 1'b1;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_cell  = b_cell_ff;

endmodule

FILE: design/dfom_div.sv
// ----------------------------------------------------------------------------
// Average divider
// Final level sum, then floor division by the remaining count, seven
// quotient bits per stage.
// ----------------------------------------------------------------------------
module dfom_div import dfom_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  cell_type             in_cell,
   output logic                 out_valid,
   output cell_type             out_cell,
   output logic signed [SW-1:0] out_avg
);

   localparam int NS = DIV_STAGES + 1;

   logic                 s_valid_ff;
   cell_type             s_cell_ff;
   logic signed [SW-1:0] s_sum_ff;
   logic [CW-1:0]        s_cnt_ff;

   logic                 d_valid_ff [NS];
   cell_type             d_cell_ff  [NS];
   logic [DW-1:0]        d_w_ff     [NS];
   logic [CW-1:0]        d_r_ff     [NS];
   logic [CW-1:0]        d_c_ff     [NS];
   logic                 d_neg_ff   [NS];

   logic                 f_valid_ff;
   cell_type             f_cell_ff;
   logic signed [SW-1:0] f_avg_ff;

   logic [CW-1:0]        div_c;
   logic                 div_neg;
   logic [DW-1:0]        div_mag;

   always_comb begin
      div_c   = (s_cnt_ff == '0) ? CW'(1) : s_cnt_ff;
      div_neg = s_sum_ff < 0;
      // floor of a negative quotient: divide -sum + c - 1 and negate
      div_mag = div_neg ? DW'(-s_sum_ff) + DW'(div_c) - DW'(1) : DW'(s_sum_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff    <= 1'b0;
         d_valid_ff[0] <= 1'b0;
         f_valid_ff    <= 1'b0;
      end else if (en) begin
         s_valid_ff    <= in_valid;
         d_valid_ff[0] <= s_valid_ff;
         f_valid_ff    <= d_valid_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_cell_ff    <= in_cell;
         s_sum_ff     <= cell_sum(in_cell);
         s_cnt_ff     <= cell_cnt(in_cell);
         d_cell_ff[0] <= s_cell_ff;
         d_w_ff[0]    <= div_mag;
         d_r_ff[0]    <= '0;
         d_c_ff[0]    <= div_c;
         d_neg_ff[0]  <= div_neg;
         f_cell_ff    <= d_cell_ff[DIV_STAGES];
         f_avg_ff     <= d_neg_ff[DIV_STAGES] ? -SW'(d_w_ff[DIV_STAGES])
                                              : SW'(d_w_ff[DIV_STAGES]);
      end
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [DW-1:0] w_in;
      logic [CW-1:0] r_in;

      // restoring steps: shift a dividend bit into the remainder, quotient into w
      always_comb begin
         logic [CW:0] t;
         logic        qb;
         w_in = d_w_ff[k];
         r_in = d_r_ff[k];
         for (int s = 0; s < DIV_STEPS; s++) begin
            t  = {r_in, w_in[DW-1]};
            qb = t >= {1'b0, d_c_ff[k]};
            r_in = qb ? CW'(t - {1'b0, d_c_ff[k]}) : CW'(t);
            w_in = {w_in[DW-2:0], qb};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d_valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            d_valid_ff[k+1] <= d_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            d_cell_ff[k+1] <= d_cell_ff[k];
            d_w_ff[k+1]    <= w_in;
            d_r_ff[k+1]    <= r_in;
            d_c_ff[k+1]    <= d_c_ff[k];
            d_neg_ff[k+1]  <= d_neg_ff[k];
         end
      end
   end

   assign out_valid = f_valid_ff;
   assign out_cell  = f_cell_ff;
   assign out_avg   = f_avg_ff;

endmodule

FILE: design/dfom_flow.sv
// ----------------------------------------------------------------------------
// Flow stage
// Difference to each neighbor, scale by relaxation, saturate. Three stages,
// the last one is the result register.
// ----------------------------------------------------------------------------
module dfom_flow import dfom_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  cell_type             in_cell,
   input  logic signed [SW-1:0] in_avg,
   input  logic [RELAX_W-1:0]   relaxation,
   output logic                 out_valid,
   output logic                 out_active,
   output logic [NB-2:0][FW-1:0] out_flow
);

   logic                        d_valid_ff;
   logic                        d_active_ff;
   logic [NB-2:0][DW-1:0]       d_diff_ff;
   logic [NB-2:0][DW-1:0]       d_diff_in;
   logic                        m_valid_ff;
   logic                        m_active_ff;
   logic [NB-2:0][PROD_W-1:0]   m_prod_ff;
   logic                        o_valid_ff;
   logic                        o_active_ff;
   logic [NB-2:0][FW-1:0]       o_flow_ff;
   logic [NB-2:0][FW-1:0]       o_flow_in;

   always_comb begin
      logic signed [SW-1:0] diff;
      for (int n = 1; n < NB; n++) begin
         diff = in_avg - SW'($signed(in_cell.lvl[n]));
         d_diff_in[n-1] = in_cell.gone[n] ? '0 : diff[DW-1:0];
      end
   end

   always_comb begin
      logic [PROD_W-RELAX_FRAC-1:0] q;
      for (int n = 0; n < NB - 1; n++) begin
         q = m_prod_ff[n][PROD_W-1:RELAX_FRAC];
         o_flow_in[n] = (q > (PROD_W-RELAX_FRAC)'(FLOW_MAX)) ? FLOW_MAX : q[FW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= in_valid;
         m_valid_ff <= d_valid_ff;
         o_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_active_ff <= in_cell.active;
         d_diff_ff   <= d_diff_in;
         m_active_ff <= d_active_ff;
         for (int n = 0; n < NB - 1; n++) begin
            m_prod_ff[n] <= PROD_W'(d_diff_ff[n]) * PROD_W'(relaxation);
         end
         o_active_ff <= m_active_ff;
         o_flow_ff   <= o_flow_in;
      end
   end

   assign out_valid  = o_valid_ff;
   assign out_active = o_active_ff;
   assign out_flow   = o_flow_ff;

endmodule

FILE: design/debris_flow_outflow_minimization.sv
// ----------------------------------------------------------------------------
// Debris outflow by minimization of differences
// One grid cell word in, one word of four neighbor outflows out.
// ----------------------------------------------------------------------------
// A new cell word is taken every cycle while the pipeline is not held; each
// word passes through entry, five elimination passes of two stages each,
// eight divider stages (final sum, setup, five stages that yield seven
// quotient bits apiece and a sign fix), then three flow stages. The whole
// pipeline holds while a result word waits on rsp_tready.
`include "debris_flow_outflow_minimization_macros.svh"

module debris_flow_outflow_minimization import dfom_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   // center_altitude, center_thickness, level_north, level_west,
   // level_east, level_south
   input  logic [191:0]   req_tdata,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   // cell_active, flow_north, flow_west, flow_east, flow_south
   output logic [127:0]   rsp_tdata,
   input  logic           csr_we,
   input  logic           csr_addr,
   input  logic [RELAX_W-1:0] csr_wdata
);

   logic [EPS_W-1:0]   eps_ff;
   logic [RELAX_W-1:0] relax_ff;
   logic               en;

   logic signed [31:0] center_altitude;
   logic [30:0]        center_thickness;

   logic               e_valid_ff;
   cell_type           e_cell_ff;
   cell_type           e_cell_in;

   logic               p_valid [PASSES+1];
   cell_type           p_cell  [PASSES+1];

   logic               v_valid;
   cell_type           v_cell;
   logic signed [SW-1:0] v_avg;

   logic               f_active;
   logic [NB-2:0][FW-1:0] f_flow;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff   <= EPS_RESET;
         relax_ff <= RELAX_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CFG_EPSILON:    eps_ff   <= csr_wdata[EPS_W-1:0];
            CFG_RELAXATION: relax_ff <= csr_wdata;
            default:        ;
         endcase
      end
   end

   assign center_altitude  = req_tdata[31:0];
   assign center_thickness = req_tdata[62:32];

   // inactive cells enter with every level gone so all flows come out zero
   always_comb begin
      e_cell_in.active = center_thickness > MW'(eps_ff);
      e_cell_in.gone   = e_cell_in.active ? '0 : '1;
      e_cell_in.mass   = center_thickness - MW'(eps_ff);
      e_cell_in.lvl[0] = LW'(center_altitude) + LW'(eps_ff);
      for (int n = 1; n < NB; n++) begin
         e_cell_in.lvl[n] = LW'($signed(req_tdata[63+32*(n-1) +: 32]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_cell_ff <= e_cell_in;
      end
   end

   assign p_valid[0] = e_valid_ff;
   assign p_cell[0]  = e_cell_ff;

   for (genvar k = 0; k < PASSES; k++) begin : g_pass
      dfom_pass u_pass (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (p_valid[k]),
         .in_cell   (p_cell[k]),
         .out_valid (p_valid[k+1]),
         .out_cell  (p_cell[k+1])
      );
   end

   dfom_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p_valid[PASSES]),
      .in_cell   (p_cell[PASSES]),
      .out_valid (v_valid),
      .out_cell  (v_cell),
      .out_avg   (v_avg)
   );

   dfom_flow u_flow (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (v_valid),
      .in_cell    (v_cell),
      .in_avg     (v_avg),
      .relaxation (relax_ff),
      .out_valid  (rsp_tvalid),
      .out_active (f_active),
      .out_flow   (f_flow)
   );

   assign rsp_tdata = {3'b0, f_flow, f_active};

   `DFOM_ASSERT_IMP(a_idle_no_flow, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[124:1] == '0, "inactive cell word carries a flow")
   `DFOM_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_tvalid, "result valid right after reset")

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Debris outflow testbench
// Streams grid cell words into the outflow block under random sender bursts
// and receiver stalls, predicts each result word from its own copy of the
// minimization-of-differences arithmetic and checks every field in order.
// ----------------------------------------------------------------------------
module testbench import dfom_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] alt;
      logic [30:0]        thick;
      logic signed [31:0] lvl [4];
   } tb_cell_type;

   typedef struct {
      logic        active;
      logic [30:0] flow [4];
   } outflow_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 30;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [191:0]         req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [127:0]         rsp_tdata;
   logic                 csr_we;
   logic                 csr_addr;
   logic [RELAX_W-1:0]   csr_wdata;

   logic [EPS_W-1:0]     eps_q;
   logic [RELAX_W-1:0]   relax_q;
   outflow_type          expected_flows [$];
   int                   mismatches;
   int                   burst_left;
   int                   hold_req;
   int                   idle_cycles;

   debris_flow_outflow_minimization u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic outflow_type predict_outflow(tb_cell_type c);
      longint lv [5];
      bit gone [5];
      longint mass, avg, sum, cnt;
      longint unsigned diff, prod, f;
      bit changed;
      outflow_type r;
      r.active = 1'b0;
      foreach (r.flow[i]) r.flow[i] = '0;
      if (longint'(c.thick) <= longint'(eps_q)) return r;
      mass  = longint'(c.thick) - longint'(eps_q);
      lv[0] = longint'(c.alt) + longint'(eps_q);
      for (int n = 1; n < 5; n++) lv[n] = longint'(c.lvl[n-1]);
      foreach (gone[n]) gone[n] = 1'b0;
      avg = mass;
      for (int p = 0; p < 6; p++) begin
         sum = mass;
         cnt = 0;
         changed = 1'b0;
         for (int n = 0; n < 5; n++) begin
            if (!gone[n]) begin
               sum += lv[n];
               cnt++;
            end
         end
         if (cnt != 0) begin
            avg = sum / cnt;
            // round toward minus infinity
            if ((sum % cnt) != 0 && sum < 0) avg--;
         end else begin
            avg = sum;
         end
         for (int n = 0; n < 5; n++) begin
            if (!gone[n] && avg <= lv[n]) begin
               gone[n] = 1'b1;
               changed = 1'b1;
            end
         end
         if (!changed) break;
      end
      r.active = 1'b1;
      for (int n = 1; n < 5; n++) begin
         if (!gone[n]) begin
            diff = longint'(avg - lv[n]);
            prod = diff * longint'(relax_q);
            f = prod >> RELAX_FRAC;
            if (f > 64'h7FFF_FFFF) f = 64'h7FFF_FFFF;
            r.flow[n-1] = f[30:0];
         end
      end
      return r;
   endfunction

   // send one cell word; valid stays high into the next word of a burst
   task automatic send_cell(tb_cell_type c);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, c.lvl[3], c.lvl[2], c.lvl[1], c.lvl[0], c.thick, c.alt};
      do @(posedge clock); while (!req_tready);
      expected_flows.push_back(predict_outflow(c));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_flows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic addr, logic [RELAX_W-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (addr == CFG_EPSILON) eps_q = value[EPS_W-1:0];
      else relax_q = value;
   endtask

   function automatic tb_cell_type make_cell(logic signed [31:0] alt, logic [30:0] thick,
                                             logic signed [31:0] n, logic signed [31:0] w,
                                             logic signed [31:0] e, logic signed [31:0] s);
      tb_cell_type c;
      c.alt = alt; c.thick = thick;
      c.lvl[0] = n; c.lvl[1] = w; c.lvl[2] = e; c.lvl[3] = s;
      return c;
   endfunction

   // mostly cells with levels close to the center so several passes run
   function automatic tb_cell_type random_cell();
      tb_cell_type c;
      int spread;
      if ($urandom_range(0, 4) == 0) begin
         c.alt = $urandom;
         c.thick = 31'($urandom);
         foreach (c.lvl[i]) c.lvl[i] = $urandom;
      end else begin
         spread = 1 << $urandom_range(4, 22);
         c.alt = $signed($urandom) >>> $urandom_range(0, 12);
         case ($urandom_range(0, 3))
            0: c.thick = 31'(eps_q + $urandom_range(0, 2) - 1);
            1: c.thick = 31'($urandom_range(0, spread));
            default: c.thick = 31'($urandom_range(0, 4 * spread));
         endcase
         foreach (c.lvl[i])
            c.lvl[i] = c.alt + $signed($urandom_range(0, 2 * spread)) - spread;
      end
      return c;
   endfunction

   task automatic test_directed();
      logic signed [31:0] mx, mn;
      mx = 32'sh7FFF_FFFF;
      mn = 32'sh8000_0000;
      send_cell(make_cell(0, 31'd0, 0, 0, 0, 0));
      send_cell(make_cell(0, 31'd66, -100, -100, -100, -100));
      send_cell(make_cell(0, 31'd67, -100, -100, -100, -100));
      send_cell(make_cell(0, 31'd65, -100, -100, -100, -100));
      send_cell(make_cell(mx, 31'h7FFF_FFFF, mn, mn, mn, mn));
      send_cell(make_cell(mn, 31'h7FFF_FFFF, mx, mx, mx, mx));
      send_cell(make_cell(mn, 31'h7FFF_FFFF, mn, mn, mn, mn));
      send_cell(make_cell(mx, 31'h7FFF_FFFF, mx, mx, mx, mx));
      send_cell(make_cell(mx, 31'd100, mn, mx, mn, mx));
      send_cell(make_cell(32'sh10000, 31'h10000, 0, 32'sh10000, 32'sh20000, -32'sh10000));
      send_cell(make_cell(0, 31'h50000, 0, 0, 0, 0));
      send_cell(make_cell(-5, 31'd70, -7, -6, -9, -8));
      send_cell(make_cell(-1, 31'd67, -2, -3, -4, -1));
      send_cell(make_cell(32'sh55555555, 31'h2AAAAAAA, 32'shAAAAAAAA, 32'sh55555555,
                          32'sh0F0F0F0F, 32'shF0F0F0F0));
      send_cell(make_cell(32'shAAAAAAAA, 31'h55555555, 32'sh55555555, 32'shAAAAAAAA,
                          32'shF0F0F0F0, 32'sh0F0F0F0F));
      send_cell(make_cell(0, 31'h100000, 32'sh400000, 32'sh400000, 32'sh400000, -1));
   endtask

   task automatic test_random(int count);
      repeat (count) send_cell(random_cell());
   endtask

   task automatic test_config_sweep();
      write_reg(CFG_EPSILON, 17'd0);
      write_reg(CFG_RELAXATION, 17'd65536);
      test_directed();
      test_random(150);
      write_reg(CFG_EPSILON, 17'd65535);
      write_reg(CFG_RELAXATION, 17'd131071);
      test_directed();
      test_random(150);
      write_reg(CFG_RELAXATION, 17'd0);
      test_random(100);
      write_reg(CFG_EPSILON, 17'd1);
      write_reg(CFG_RELAXATION, 17'd1);
      test_random(100);
      write_reg(CFG_EPSILON, 17'h1AAAA);
      write_reg(CFG_RELAXATION, 17'h15555);
      test_random(150);
   endtask

   task automatic test_backpressure();
      hold_req = 400;
      test_random(80);
      drain();
      test_random(200);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = CFG_EPSILON;
      csr_wdata  = '0;
      eps_q      = EPS_RESET;
      relax_q    = RELAX_RESET;
      mismatches = 0;
      burst_left = 0;
      hold_req   = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300);
      test_backpressure();
      test_config_sweep();
      write_reg(CFG_EPSILON, 17'd66);
      write_reg(CFG_RELAXATION, 17'd32768);
      test_random(500);
      drain();
      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver: long hold-off on request, otherwise a shifting stall rate
   int hold_cnt;
   int stall_pct;
   initial begin
      hold_cnt = 0;
      stall_pct = 0;
   end
   always @(posedge clock) begin
      if (hold_req > 0) begin
         hold_cnt = hold_req;
         hold_req = 0;
      end
      if ($urandom_range(0, 99) == 0) stall_pct = $urandom_range(0, 3) * 25;
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      outflow_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_flows.size() == 0) begin
            $error("result word with nothing expected");
            mismatches++;
         end else begin
            exp_r = expected_flows.pop_front();
            if (rsp_tdata[0] !== exp_r.active) begin
               $error("cell_active expected %0d got %0d", exp_r.active, rsp_tdata[0]);
               mismatches++;
            end
            if (rsp_tdata[31:1] !== exp_r.flow[0]) begin
               $error("flow_north expected %0d got %0d", exp_r.flow[0], rsp_tdata[31:1]);
               mismatches++;
            end
            if (rsp_tdata[62:32] !== exp_r.flow[1]) begin
               $error("flow_west expected %0d got %0d", exp_r.flow[1], rsp_tdata[62:32]);
               mismatches++;
            end
            if (rsp_tdata[93:63] !== exp_r.flow[2]) begin
               $error("flow_east expected %0d got %0d", exp_r.flow[2], rsp_tdata[93:63]);
               mismatches++;
            end
            if (rsp_tdata[124:94] !== exp_r.flow[3]) begin
               $error("flow_south expected %0d got %0d", exp_r.flow[3], rsp_tdata[124:94]);
               mismatches++;
            end
         end
      end
   end

   initial idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

endmodule

FILE: sim.f
+incdir+design
design/dfom_pkg.sv
design/dfom_pass.sv
design/dfom_div.sv
design/dfom_flow.sv
design/debris_flow_outflow_minimization.sv
verif/testbench.sv
